/* rtl/inorder_completion_tracker_unit_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef INORDER_COMPLETION_TRACKER_UNIT_ASSERT_SVH
`define INORDER_COMPLETION_TRACKER_UNIT_ASSERT_SVH

// Clocked assertion with an active-low reset that disables it.
`define ICT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, for a property that must also hold while reset is asserted.
`define ICT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ict_pkg.sv */
`default_nettype none
package ict_pkg;

  typedef struct packed {
    logic [47:0] off;
    logic [23:0] len;
    logic [31:0] ver;
  } ict_entry_t;

  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_POP    = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    ict_entry_t key;
  } ict_cell_ctl_t;

  localparam logic [2:0] ST_IN_ORDER   = 3'd0;
  localparam logic [2:0] ST_ABOVE_MAX  = 3'd1;
  localparam logic [2:0] ST_BELOW_MAX  = 3'd2;
  localparam logic [2:0] ST_DUPLICATE  = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;
  localparam logic [2:0] ST_FORCED     = 3'd5;

endpackage
`default_nettype wire

/* rtl/inorder_completion_tracker_unit.sv */
// Flow: an in-order submit passes the drain state, which pops entries one per cycle, and
// then the response state; an out-of-order submit passes the check and response states; a
// force pops all N pending entries, then responds. A new transfer is taken in the cycle after
// the result is loaded; a stalled result holds the next one in its last step.
// Reset: synchronous active low; clears the table, expected offset, version,
// highest stored offset and the output valid.
`default_nettype none
module inorder_completion_tracker_unit #(
  parameter int PENDING_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [47:0] cfg_start_offset,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [47:0] in_record_offset,
  input  wire logic [23:0] in_record_length,
  input  wire logic [31:0] in_record_version,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [47:0]      out_expected_offset_out,
  output logic [31:0]      out_expected_version_out,
  output logic [6:0]       out_drained_count,
  output logic [6:0]       out_pending_count
);

  localparam int CW = $clog2(PENDING_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_FORCE = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  ict_pkg::ict_entry_t item_r, item_nxt;
  ict_pkg::ict_entry_t top_r, top_nxt;
  logic [47:0]         exp_off_r, exp_off_nxt;
  logic [31:0]         exp_ver_r, exp_ver_nxt;
  logic [47:0]         max_off_r, max_off_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       drained_r, drained_nxt;
  logic [2:0]          status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          out_status_r;
  logic [47:0]         out_off_r;
  logic [31:0]         out_ver_r;
  logic [6:0]          out_drained_r, out_pending_r;
  logic                load_out;

  ict_pkg::ict_cell_ctl_t ctl;
  ict_pkg::ict_entry_t    cell_e [PENDING_DEPTH];
  logic [PENDING_DEPTH-1:0] cell_v, cell_lt, cell_hit;

  // The row of cells: each takes its neighbors' entries on insert or pop.
  for (genvar i = 0; i < PENDING_DEPTH; i++) begin : g_cell
    ict_pkg::ict_entry_t pe, ne;
    logic pv, plt, nv;
    if (i == 0) begin : g_first
      assign pe  = ctl.key;
      assign pv  = 1'b1;
      assign plt = 1'b1;
    end else begin : g_mid
      assign pe  = cell_e[i-1];
      assign pv  = cell_v[i-1];
      assign plt = cell_lt[i-1];
    end
    if (i == PENDING_DEPTH - 1) begin : g_last
      assign ne = ctl.key;
      assign nv = 1'b0;
    end else begin : g_inner
      assign ne = cell_e[i+1];
      assign nv = cell_v[i+1];
    end
    ict_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_entry (pe),
      .prev_valid (pv),
      .prev_lt    (plt),
      .next_entry (ne),
      .next_valid (nv),
      .entry      (cell_e[i]),
      .valid      (cell_v[i]),
      .lt         (cell_lt[i]),
      .hit        (cell_hit[i])
    );
  end

  assign in_stall  = (state_r != S_IDLE);
  assign load_out  = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    top_nxt       = top_r;
    exp_off_nxt   = exp_off_r;
    exp_ver_nxt   = exp_ver_r;
    max_off_nxt   = max_off_r;
    count_nxt     = count_r;
    drained_nxt   = drained_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctl.op        = ict_pkg::CELL_HOLD;
    ctl.key       = item_r;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          exp_off_nxt = cfg_start_offset;
        end
        if (in_valid) begin
          item_nxt.off = in_record_offset;
          item_nxt.len = in_record_length;
          item_nxt.ver = in_record_version;
          drained_nxt  = '0;
          if (in_func) begin
            state_nxt = S_FORCE;
          end else if (in_record_offset <= exp_off_r) begin
            // At the expected offset the record advances it; below, only drain.
            if (in_record_offset == exp_off_r) begin
              exp_off_nxt = exp_off_r + 48'(in_record_length);
              exp_ver_nxt = in_record_version;
            end
            state_nxt = S_DRAIN;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (|cell_hit) begin
          status_nxt = ict_pkg::ST_DUPLICATE;
        end else if (count_r == CW'(PENDING_DEPTH)) begin
          status_nxt = ict_pkg::ST_TABLE_FULL;
        end else begin
          ctl.op    = ict_pkg::CELL_INSERT;
          count_nxt = count_r + 1'b1;
          if (item_r.off > max_off_r) begin
            max_off_nxt = item_r.off;
            status_nxt  = ict_pkg::ST_ABOVE_MAX;
          end else begin
            status_nxt  = ict_pkg::ST_BELOW_MAX;
          end
        end
        state_nxt = S_RESP;
      end
      S_DRAIN: begin
        // Cell 0 holds the smallest pending offset.
        if (cell_v[0] && (cell_e[0].off <= exp_off_r)) begin
          ctl.op = ict_pkg::CELL_POP;
          if (cell_e[0].off == exp_off_r) begin
            exp_off_nxt = exp_off_r + 48'(cell_e[0].len);
            exp_ver_nxt = cell_e[0].ver;
          end
          count_nxt   = count_r - 1'b1;
          drained_nxt = drained_r + 1'b1;
        end else begin
          status_nxt = ict_pkg::ST_IN_ORDER;
          state_nxt  = S_RESP;
        end
      end
      S_FORCE: begin
        // Popping in ascending order leaves the highest entry in top_r.
        if (count_r != '0) begin
          ctl.op      = ict_pkg::CELL_POP;
          top_nxt     = cell_e[0];
          count_nxt   = count_r - 1'b1;
          drained_nxt = drained_r + 1'b1;
        end else begin
          if (drained_r != '0) begin
            exp_off_nxt = top_r.off + 48'(top_r.len);
            exp_ver_nxt = top_r.ver;
          end
          status_nxt = ict_pkg::ST_FORCED;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exp_off_r   <= '0;
      exp_ver_r   <= '0;
      max_off_r   <= '0;
      count_r     <= '0;
      drained_r   <= '0;
      status_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_off_r   <= exp_off_nxt;
      exp_ver_r   <= exp_ver_nxt;
      max_off_r   <= max_off_nxt;
      count_r     <= count_nxt;
      drained_r   <= drained_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    top_r  <= top_nxt;
    if (load_out) begin
      out_status_r  <= status_r;
      out_off_r     <= exp_off_r;
      out_ver_r     <= exp_ver_r;
      out_drained_r <= 7'(drained_r);
      out_pending_r <= 7'(count_r);
    end
  end

  assign out_valid                = out_valid_r;
  assign out_status               = out_status_r;
  assign out_expected_offset_out  = out_off_r;
  assign out_expected_version_out = out_ver_r;
  assign out_drained_count        = out_drained_r;
  assign out_pending_count        = out_pending_r;

endmodule
`default_nettype wire

/* rtl/ict_cell.sv */
`default_nettype none
// One slot of the sorted pending row. Cells stay ordered by ascending offset,
// valid ones packed at the low end.
module ict_cell (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire ict_pkg::ict_cell_ctl_t ctl,
  input  wire ict_pkg::ict_entry_t    prev_entry,
  input  wire logic                   prev_valid,
  input  wire logic                   prev_lt,
  input  wire ict_pkg::ict_entry_t    next_entry,
  input  wire logic                   next_valid,
  output ict_pkg::ict_entry_t         entry,
  output logic                        valid,
  output logic                        lt,
  output logic                        hit
);

  ict_pkg::ict_entry_t entry_r, entry_nxt;
  logic                valid_r, valid_nxt;

  assign entry = entry_r;
  assign valid = valid_r;
  assign lt    = valid_r && (entry_r.off < ctl.key.off);
  assign hit   = valid_r && (entry_r.off == ctl.key.off);

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    case (ctl.op)
      ict_pkg::CELL_INSERT: begin
        // A cell below the key keeps its entry; the first one above takes the
        // key and the rest shift up by one.
        if (!lt) begin
          if (prev_lt) begin
            entry_nxt = ctl.key;
            valid_nxt = 1'b1;
          end else begin
            entry_nxt = prev_entry;
            valid_nxt = prev_valid;
          end
        end
      end
      ict_pkg::CELL_POP: begin
        entry_nxt = next_entry;
        valid_nxt = next_valid;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

/* rtl/ict_checker.sv */
`default_nettype none
`include "inorder_completion_tracker_unit_assert.svh"
module ict_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_status,
  input wire logic [6:0]  out_drained_count
);

  `ICT_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped")
  `ICT_ASSERT(a_status_range, clk, rst_n, out_valid |-> out_status <= ict_pkg::ST_FORCED, "bad status")
  `ICT_ASSERT(a_stored_no_drain, clk, rst_n, out_valid && (out_status == ict_pkg::ST_ABOVE_MAX || out_status == ict_pkg::ST_BELOW_MAX || out_status == ict_pkg::ST_DUPLICATE || out_status == ict_pkg::ST_TABLE_FULL) |-> out_drained_count == 7'd0, "drain on store")
  `ICT_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "valid after reset")

endmodule

bind inorder_completion_tracker_unit ict_checker u_ict_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_drained_count (out_drained_count)
);
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  // Operation codes of the func field.
  localparam bit FUNC_SUBMIT = 1'b0;
  localparam bit FUNC_FORCE  = 1'b1;
  localparam int DEPTH       = 64;
  localparam bit [47:0] OFF_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    bit        func;
    bit [47:0] off;
    bit [23:0] len;
    bit [31:0] ver;
  } completion_t;

  typedef struct {
    bit [2:0]  status;
    bit [47:0] exp_off;
    bit [31:0] exp_ver;
    bit [6:0]  drained;
    bit [6:0]  pending;
  } commit_t;

  typedef struct {
    completion_t c;
    commit_t     e;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [47:0] cfg_start_offset = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = 1'b0;
  logic [47:0] in_record_offset = '0;
  logic [23:0] in_record_length = '0;
  logic [31:0] in_record_version = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [47:0] out_expected_offset_out;
  logic [31:0] out_expected_version_out;
  logic [6:0]  out_drained_count;
  logic [6:0]  out_pending_count;

  // Tracker state as the testbench sees it.
  bit [47:0] trk_expected_off;
  bit [31:0] trk_expected_ver;
  bit [47:0] trk_max_stored;
  bit [47:0] slot_off [DEPTH];
  bit [23:0] slot_len [DEPTH];
  bit [31:0] slot_ver [DEPTH];
  bit        slot_used [DEPTH];

  commit_t   pending_commits[$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        results_seen = 0;
  int        status_hits [8];
  int        stall_hold_req = 0;
  int        sender_calm = 0;

  inorder_completion_tracker_unit dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_we                   (cfg_we),
    .cfg_start_offset         (cfg_start_offset),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_func                  (in_func),
    .in_record_offset         (in_record_offset),
    .in_record_length         (in_record_length),
    .in_record_version        (in_record_version),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_status               (out_status),
    .out_expected_offset_out  (out_expected_offset_out),
    .out_expected_version_out (out_expected_version_out),
    .out_drained_count        (out_drained_count),
    .out_pending_count        (out_pending_count)
  );

  always #4 clk = ~clk;

  // A generous ceiling on the whole run.
  initial begin
    #20ms;
    $display("Timeout with %0d results still outstanding.", pending_commits.size());
    $display("== FAIL ==");
    $finish;
  end

  // Works out the result of one completion and updates the tracker state.
  // Offsets in the table are unique, so the slot an entry lands in does not
  // change any visible result.
  function automatic commit_t commit_predict(completion_t c);
    commit_t r;
    int      top;
    int      low;
    int      freeslot;
    bit      dup;
    int      drained;
    int      used;
    drained = 0;
    if (c.func == FUNC_FORCE) begin
      top = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_used[i]) begin
          if (top < 0 || slot_off[i] > slot_off[top]) top = i;
          slot_used[i] = 1'b0;
          drained++;
        end
      end
      if (top >= 0) begin
        trk_expected_off = slot_off[top] + 48'(slot_len[top]);
        trk_expected_ver = slot_ver[top];
      end
      r.status = ict_pkg::ST_FORCED;
    end else if (c.off <= trk_expected_off) begin
      if (c.off == trk_expected_off) begin
        trk_expected_ver = c.ver;
        trk_expected_off = trk_expected_off + 48'(c.len);
      end
      // Drain the smallest stored offsets while they are not ahead of us.
      while (1) begin
        low = -1;
        for (int i = 0; i < DEPTH; i++)
          if (slot_used[i] && (low < 0 || slot_off[i] < slot_off[low])) low = i;
        if (low < 0 || slot_off[low] > trk_expected_off) break;
        if (slot_off[low] == trk_expected_off) begin
          trk_expected_ver = slot_ver[low];
          trk_expected_off = trk_expected_off + 48'(slot_len[low]);
        end
        slot_used[low] = 1'b0;
        drained++;
      end
      r.status = ict_pkg::ST_IN_ORDER;
    end else begin
      freeslot = -1;
      dup = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_used[i]) begin
          if (slot_off[i] == c.off) dup = 1'b1;
        end else if (freeslot < 0) begin
          freeslot = i;
        end
      end
      if (dup) begin
        r.status = ict_pkg::ST_DUPLICATE;
      end else if (freeslot < 0) begin
        r.status = ict_pkg::ST_TABLE_FULL;
      end else begin
        if (c.off > trk_max_stored) begin
          trk_max_stored = c.off;
          r.status = ict_pkg::ST_ABOVE_MAX;
        end else begin
          r.status = ict_pkg::ST_BELOW_MAX;
        end
        slot_off[freeslot]  = c.off;
        slot_len[freeslot]  = c.len;
        slot_ver[freeslot]  = c.ver;
        slot_used[freeslot] = 1'b1;
      end
    end
    used = 0;
    for (int i = 0; i < DEPTH; i++) used += slot_used[i];
    r.exp_off = trk_expected_off;
    r.exp_ver = trk_expected_ver;
    r.drained = 7'(drained);
    r.pending = 7'(used);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
             $realtime, results_seen, field, got, want);
    mismatches++;
  endtask

  // Result checker: every transfer on the result channel is compared with
  // the oldest expectation.
  always @(posedge clk) begin
    commit_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_commits.size() == 0) begin
        report_mismatch("unexpected transfer", 64'd1, 64'd0);
      end else begin
        want = pending_commits.pop_front();
        if (out_status != want.status)
          report_mismatch("status", out_status, want.status);
        if (out_expected_offset_out != want.exp_off)
          report_mismatch("expected_offset", out_expected_offset_out, want.exp_off);
        if (out_expected_version_out != want.exp_ver)
          report_mismatch("expected_version", out_expected_version_out, want.exp_ver);
        if (out_drained_count != want.drained)
          report_mismatch("drained_count", out_drained_count, want.drained);
        if (out_pending_count != want.pending)
          report_mismatch("pending_count", out_pending_count, want.pending);
        status_hits[want.status]++;
      end
      results_seen++;
    end
  end

  // Receiver stall. Bursts of random length, mostly short, with calm
  // stretches; a long hold-off is taken when the stimulus asks for one.
  initial begin
    int burst;
    int r;
    burst = 0;
    forever begin
      @(negedge clk);
      if (stall_hold_req > 0) begin
        out_stall = 1'b1;
        repeat (stall_hold_req) @(negedge clk);
        stall_hold_req = 0;
        out_stall = 1'b0;
      end else if (burst > 0) begin
        burst--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_stall = 1'b0;
          burst = $urandom_range(1, 25);
        end else if (r < 92) begin
          out_stall = 1'b1;
          burst = $urandom_range(0, 2);
        end else begin
          out_stall = 1'b1;
          burst = $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int sender_gap();
    int r;
    if (sender_calm > 0) begin
      sender_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 10) sender_calm = $urandom_range(5, 30);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one completion and waits for the transfer. Valid stays high
  // afterwards so that back-to-back items need no extra cycle.
  task automatic send_completion(completion_t c, bit typed, commit_t e);
    int      gap;
    commit_t r;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          = 1'b1;
    in_func           = c.func;
    in_record_offset  = c.off;
    in_record_length  = c.len;
    in_record_version = c.ver;
    do @(posedge clk); while (in_stall);
    r = commit_predict(c);
    if (typed) r = e;
    pending_commits = {pending_commits, r};
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_checked(completion_t c);
    commit_t unused;
    unused = '{default: '0};
    send_completion(c, 1'b0, unused);
  endtask

  // Lets the block go idle, then loads a new start offset.
  task automatic write_start_offset(bit [47:0] value);
    in_valid = 1'b0;
    wait (pending_commits.size() == 0);
    repeat (80) @(negedge clk);
    cfg_we = 1'b1;
    cfg_start_offset = value;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_start_offset = ~value;
    trk_expected_off = value;
  endtask

  function automatic completion_t random_completion();
    completion_t c;
    c.func = 1'($urandom_range(0, 9) == 0);
    c.off  = {16'($urandom), 32'($urandom)};
    c.len  = 24'($urandom);
    c.ver  = $urandom;
    return c;
  endfunction

  // A run of consecutive records starting at the expected offset, handed
  // in shuffled order. Now and then one record is held back so the rest
  // stay in the table until a later force or completion.
  task automatic send_record_run();
    completion_t run [$];
    completion_t c;
    completion_t t;
    bit [47:0]   cursor;
    int          n;
    int          j;
    cursor = trk_expected_off;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      c.func = FUNC_SUBMIT;
      c.off  = cursor;
      c.len  = ($urandom_range(0, 99) < 90) ? 24'($urandom_range(0, 64)) : 24'($urandom);
      c.ver  = $urandom;
      cursor = cursor + 48'(c.len);
      run = {run, c};
    end
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = run[i];
      run[i] = run[j];
      run[j] = t;
    end
    if (n > 2 && $urandom_range(0, 4) == 0) void'(run.pop_back());
    foreach (run[i]) send_checked(run[i]);
  endtask

  // Fills the table well ahead of the expected offset, under a long
  // receiver hold-off, then probes the duplicate and full cases and ends with a force.
  task automatic fill_table();
    completion_t c;
    bit [47:0]   base;
    base = trk_expected_off + 48'd5000;
    stall_hold_req = 300;
    for (int i = 0; i < DEPTH + 2; i++) begin
      c.func = FUNC_SUBMIT;
      c.off  = base + 48'($urandom_range(0, 3)) + 48'(i * 8) * (i % 2 ? 1 : 2);
      c.len  = 24'($urandom_range(1, 8));
      c.ver  = $urandom;
      send_checked(c);
    end
    c.off = base + 48'd2;
    send_checked(c);
    c.off = base + 48'd100001;
    send_checked(c);
    c.func = FUNC_FORCE;
    send_checked(c);
  endtask

  task automatic send_random_phase(int count);
    completion_t c;
    int          stop;
    int          r;
    stop = items_sent + count;
    while (items_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        send_record_run();
      end else if (r < 70) begin
        c = random_completion();
        c.func = FUNC_SUBMIT;
        c.off  = trk_expected_off - 48'($urandom_range(0, 200));
        send_checked(c);
      end else if (r < 78) begin
        c = random_completion();
        c.func = FUNC_FORCE;
        send_checked(c);
      end else if (r < 97) begin
        send_checked(random_completion());
      end else begin
        fill_table();
      end
    end
  endtask

  directed_row_t directed_rows [12];

  initial begin
    // Expected results after reset with a start offset of zero.
    directed_rows[0]  = '{'{FUNC_SUBMIT, 48'd0, 24'd16, 32'hAAAA},
                          '{ict_pkg::ST_IN_ORDER, 48'd16, 32'hAAAA, 7'd0, 7'd0}};
    directed_rows[1]  = '{'{FUNC_SUBMIT, 48'd32, 24'd8, 32'd2},
                          '{ict_pkg::ST_ABOVE_MAX, 48'd16, 32'hAAAA, 7'd0, 7'd1}};
    directed_rows[2]  = '{'{FUNC_SUBMIT, 48'd24, 24'd8, 32'd3},
                          '{ict_pkg::ST_BELOW_MAX, 48'd16, 32'hAAAA, 7'd0, 7'd2}};
    directed_rows[3]  = '{'{FUNC_SUBMIT, 48'd32, 24'd1, 32'd7},
                          '{ict_pkg::ST_DUPLICATE, 48'd16, 32'hAAAA, 7'd0, 7'd2}};
    // Closing the hole drains both stored records.
    directed_rows[4]  = '{'{FUNC_SUBMIT, 48'd16, 24'd8, 32'd4},
                          '{ict_pkg::ST_IN_ORDER, 48'd40, 32'd2, 7'd2, 7'd0}};
    directed_rows[5]  = '{'{FUNC_SUBMIT, 48'd5, 24'hFFFFFF, 32'hFFFFFFFF},
                          '{ict_pkg::ST_IN_ORDER, 48'd40, 32'd2, 7'd0, 7'd0}};
    directed_rows[6]  = '{'{FUNC_SUBMIT, 48'd100, 24'd1, 32'd9},
                          '{ict_pkg::ST_ABOVE_MAX, 48'd40, 32'd2, 7'd0, 7'd1}};
    directed_rows[7]  = '{'{FUNC_FORCE, OFF_MAX, 24'hFFFFFF, 32'hFFFFFFFF},
                          '{ict_pkg::ST_FORCED, 48'd101, 32'd9, 7'd1, 7'd0}};
    directed_rows[8]  = '{'{FUNC_FORCE, 48'd0, 24'd0, 32'd0},
                          '{ict_pkg::ST_FORCED, 48'd101, 32'd9, 7'd0, 7'd0}};
    directed_rows[9]  = '{'{FUNC_SUBMIT, OFF_MAX, 24'hFFFFFF, 32'hFFFFFFFF},
                          '{ict_pkg::ST_ABOVE_MAX, 48'd101, 32'd9, 7'd0, 7'd1}};
    // A zero-length record takes the version but leaves the offset.
    directed_rows[10] = '{'{FUNC_SUBMIT, 48'd101, 24'd0, 32'd0},
                          '{ict_pkg::ST_IN_ORDER, 48'd101, 32'd0, 7'd0, 7'd1}};
    // Forcing past the top entry wraps the offset.
    directed_rows[11] = '{'{FUNC_FORCE, 48'd0, 24'd0, 32'd0},
                          '{ict_pkg::ST_FORCED, 48'hFFFFFE, 32'hFFFFFFFF, 7'd1, 7'd0}};

    trk_expected_off = '0;
    trk_expected_ver = '0;
    trk_max_stored   = '0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_completion(directed_rows[i].c, 1'b1, directed_rows[i].e);

    send_random_phase(300);
    write_start_offset(OFF_MAX - 48'd40);
    send_random_phase(250);
    write_start_offset(48'd0);
    fill_table();
    send_random_phase(250);
    write_start_offset({16'($urandom), 32'($urandom)});
    send_random_phase(250);
    write_start_offset(OFF_MAX);
    send_random_phase(200);

    in_valid = 1'b0;
    wait (pending_commits.size() == 0);
    repeat (100) @(posedge clk);

    $display("Sent %0d completions across five start offsets; %0d results checked.",
             items_sent, results_seen);
    $display("Status mix: in-order %0d, above %0d, below %0d, dup %0d, full %0d, forced %0d.",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5]);
    if (mismatches == 0 && pending_commits.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/ict_pkg.sv
rtl/ict_cell.sv
rtl/inorder_completion_tracker_unit.sv
rtl/ict_checker.sv
sim/testbench.sv
